/* src/sdspi_pkg.sv */
// shared types, codes and constants of the sd spi-mode card initialisation sequencer
// no dependencies; used by every module under src
package sdspi_pkg;

    // register indexes on the configuration port (paddr[2])
    localparam logic REG_RETRY_LIMIT  = 1'b0;
    localparam logic REG_BLOCK_LENGTH = 1'b1;

    localparam logic [15:0] RETRY_LIMIT_RST  = 16'd1000;
    localparam logic [12:0] BLOCK_LENGTH_RST = 13'd512;

    // item kinds on the input channel
    localparam logic OP_START = 1'b0;
    localparam logic OP_RESP  = 1'b1;

    // command numbers
    localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
    localparam logic [5:0] CMD_SEND_OP    = 6'd1;
    localparam logic [5:0] CMD_IF_COND    = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD   = 6'd9;
    localparam logic [5:0] CMD_BLOCKLEN   = 6'd16;
    localparam logic [5:0] CMD_SD_OP_COND = 6'd41;
    localparam logic [5:0] CMD_APP        = 6'd55;
    localparam logic [5:0] CMD_READ_OCR   = 6'd58;

    localparam logic [31:0] IF_COND_ARG   = 32'h0000_01AA;
    localparam logic [15:0] IF_COND_ECHO  = 16'h01AA;
    localparam logic [31:0] HCS_ARG       = 32'h4000_0000;
    localparam int          CCS_BIT       = 30;

    // r1 status bits
    localparam logic [7:0] R1_IDLE      = 8'h01;
    localparam logic [7:0] R1_ILLEGAL   = 8'h04;
    localparam logic [7:0] R1_CRC       = 8'h08;
    localparam logic [7:0] R1_ERASE     = 8'h12;
    localparam logic [7:0] R1_PARAM     = 8'h60;

    typedef enum logic [1:0] {
        RESP_R1 = 2'd0,
        RESP_R2 = 2'd1,
        RESP_R3 = 2'd2,
        RESP_R7 = 2'd3
    } t_resp;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_CARD     = 3'd1,
        ST_CRC         = 3'd2,
        ST_ERASE       = 3'd3,
        ST_PARAM       = 3'd4,
        ST_UNSUPPORTED = 3'd5,
        ST_NO_RESPONSE = 3'd6,
        ST_LINK        = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        CARD_UNKNOWN = 3'd0,
        CARD_SD_V1   = 3'd1,
        CARD_MMC     = 3'd2,
        CARD_SD_V2SC = 3'd3,
        CARD_SD_V2HC = 3'd4
    } t_card;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_CMD0   = 4'd1,
        PH_CMD8   = 4'd2,
        PH_CMD55  = 4'd3,
        PH_ACMD41 = 4'd4,
        PH_CMD1   = 4'd5,
        PH_CMD58  = 4'd6,
        PH_CMD16  = 4'd7,
        PH_CMD9   = 4'd8
    } t_phase;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_FINISH,
        ACT_CMD0,
        ACT_CMD8,
        ACT_CMD55_NEW,
        ACT_CMD55_RETRY,
        ACT_ACMD41,
        ACT_CMD1_NEW,
        ACT_CMD1_RETRY,
        ACT_CMD58,
        ACT_CMD16,
        ACT_CMD9
    } t_act;

    typedef struct packed {
        logic [15:0] retry_limit;
        logic [12:0] block_length;
    } t_cfg;

    typedef struct packed {
        logic        op;
        logic        card_absent;
        logic        link_error;
        logic [7:0]  r1_byte;
        logic [31:0] trailer;
        logic [63:0] csd_high;
        logic [63:0] csd_low;
    } t_item;

    typedef struct packed {
        logic [5:0]  cmd_index;
        logic [31:0] cmd_arg;
        t_resp       resp_kind;
        logic        done_res;
        t_status     status;
        t_card       card_type;
        logic [31:0] block_count;
        logic        fast_clock;
    } t_res;

    typedef struct packed {
        logic        ok;
        logic [31:0] count;
    } t_csd;

    typedef struct packed {
        t_act    act;
        t_status status;
        t_card   new_type;
        logic    type_we;
        logic    hcr;
        logic    clear;
    } t_dec;

    // crc first, then erase, then parameter/address, then illegal command
    function automatic t_status classify_r1(input logic [7:0] r);
        t_status s;
        if ((r & R1_CRC) != 8'd0)          s = ST_CRC;
        else if ((r & R1_ERASE) != 8'd0)   s = ST_ERASE;
        else if ((r & R1_PARAM) != 8'd0)   s = ST_PARAM;
        else if ((r & R1_ILLEGAL) != 8'd0) s = ST_UNSUPPORTED;
        else                               s = ST_OK;
        return s;
    endfunction

endpackage

/* src/sdspi_cfg_regs.sv */
// apb-style configuration registers: retry limit and cmd16 block length
// depends on sdspi_pkg
module sdspi_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output sdspi_pkg::t_cfg   o_cfg
);

    logic [15:0] r_retry_limit;
    logic [12:0] r_block_length;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit  <= sdspi_pkg::RETRY_LIMIT_RST;
            r_block_length <= sdspi_pkg::BLOCK_LENGTH_RST;
        end else if (w_wr) begin
            unique case (paddr[2])
                sdspi_pkg::REG_RETRY_LIMIT:  r_retry_limit  <= pwdata[15:0];
                sdspi_pkg::REG_BLOCK_LENGTH: r_block_length <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            sdspi_pkg::REG_RETRY_LIMIT:  prdata = {16'd0, r_retry_limit};
            sdspi_pkg::REG_BLOCK_LENGTH: prdata = {19'd0, r_block_length};
            default:                     prdata = 32'd0;
        endcase
    end

    assign o_cfg.retry_limit  = r_retry_limit;
    assign o_cfg.block_length = r_block_length;

endmodule

/* src/sdspi_csd.sv */
// csd structure check against card type and capacity in 512-byte blocks
// depends on sdspi_pkg
module sdspi_csd (
    input  logic [63:0]       i_csd_high,
    input  logic [63:0]       i_csd_low,
    input  sdspi_pkg::t_card  i_card,
    output sdspi_pkg::t_csd   o_csd
);

    logic [1:0]  w_struct;
    logic        w_v2;
    // v1 / mmc fields
    logic [11:0] w_c_size;
    logic [2:0]  w_mult;
    logic [3:0]  w_bl_len;
    logic [12:0] w_size_p1;
    logic [4:0]  w_shift;
    logic [36:0] w_bytes;
    // v2 fields
    logic [21:0] w_c_size2;
    logic [22:0] w_size2_p1;
    logic [32:0] w_blocks2;

    assign w_struct = i_csd_high[63:62];

    always_comb begin
        o_csd.ok = ((w_struct == 2'd0) && ((i_card == sdspi_pkg::CARD_SD_V1)
                                        || (i_card == sdspi_pkg::CARD_SD_V2SC)))
                || ((w_struct == 2'd1) && (i_card == sdspi_pkg::CARD_SD_V2HC))
                || ((w_struct <= 2'd1) && (i_card == sdspi_pkg::CARD_MMC));
    end

    assign w_v2 = (w_struct == 2'd1) && (i_card == sdspi_pkg::CARD_SD_V2HC);

    // bytes 6..8, 9..10 and 5 of the csd
    assign w_c_size  = {i_csd_high[9:0], i_csd_low[63:62]};
    assign w_mult    = {i_csd_low[49:48], i_csd_low[47]};
    assign w_bl_len  = i_csd_high[19:16];
    assign w_size_p1 = {1'b0, w_c_size} + 13'd1;
    assign w_shift   = 5'(w_mult) + 5'd2 + 5'(w_bl_len);
    assign w_bytes   = 37'(w_size_p1) << w_shift;

    // c_size of a v2 csd is bytes 7 (low six bits), 8 and 9
    assign w_c_size2  = {i_csd_high[5:0], i_csd_low[63:48]};
    assign w_size2_p1 = {1'b0, w_c_size2} + 23'd1;
    assign w_blocks2  = {w_size2_p1, 10'd0};

    always_comb begin
        if (w_v2) begin
            o_csd.count = w_blocks2[32] ? 32'hFFFF_FFFF : w_blocks2[31:0];
        end else begin
            o_csd.count = {4'd0, w_bytes[36:9]};
        end
    end

endmodule

/* src/sdspi_seq.sv */
// sequencer state and per-item decision: next command or final result
// depends on sdspi_pkg and sdspi_csd
module sdspi_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  sdspi_pkg::t_item  i_item,
    input  sdspi_pkg::t_cfg   i_cfg,
    output logic              o_res_valid,
    output sdspi_pkg::t_res   o_res,
    output sdspi_pkg::t_phase o_phase
);

    sdspi_pkg::t_phase  r_phase, n_phase;
    sdspi_pkg::t_card   r_type, n_type;
    logic [15:0]        r_attempts, n_attempts;
    logic               r_hcr, n_hcr;

    sdspi_pkg::t_dec    w_dec;
    sdspi_pkg::t_csd    w_csd;
    sdspi_pkg::t_status w_err;
    logic               w_to_cmd1;

    sdspi_csd u_csd (
        .i_csd_high (i_item.csd_high),
        .i_csd_low  (i_item.csd_low),
        .i_card     (r_type),
        .o_csd      (w_csd)
    );

    assign w_err     = sdspi_pkg::classify_r1(i_item.r1_byte);
    // sd v1 path falls back to cmd1 on any op-cond failure
    assign w_to_cmd1 = (r_phase != sdspi_pkg::PH_CMD1) && !r_hcr;

    // decision
    always_comb begin
        w_dec          = '0;
        w_dec.act      = sdspi_pkg::ACT_NONE;
        w_dec.status   = sdspi_pkg::ST_OK;
        w_dec.new_type = sdspi_pkg::CARD_UNKNOWN;
        if (i_item.op == sdspi_pkg::OP_START) begin
            w_dec.clear = 1'b1;
            if (i_item.card_absent) begin
                w_dec.act    = sdspi_pkg::ACT_FINISH;
                w_dec.status = sdspi_pkg::ST_NO_CARD;
            end else begin
                w_dec.act = sdspi_pkg::ACT_CMD0;
            end
        end else if (r_phase == sdspi_pkg::PH_IDLE) begin
            w_dec.act = sdspi_pkg::ACT_NONE;
        end else if (i_item.link_error) begin
            if ((r_phase == sdspi_pkg::PH_CMD55 || r_phase == sdspi_pkg::PH_ACMD41
                 || r_phase == sdspi_pkg::PH_CMD1) && w_to_cmd1) begin
                w_dec.act = sdspi_pkg::ACT_CMD1_NEW;
            end else begin
                w_dec.act    = sdspi_pkg::ACT_FINISH;
                w_dec.status = sdspi_pkg::ST_LINK;
            end
        end else begin
            unique case (r_phase)
                sdspi_pkg::PH_CMD0: begin
                    if (w_err != sdspi_pkg::ST_OK) begin
                        w_dec.act    = sdspi_pkg::ACT_FINISH;
                        w_dec.status = w_err;
                    end else if ((i_item.r1_byte & sdspi_pkg::R1_IDLE) == 8'd0) begin
                        w_dec.act    = sdspi_pkg::ACT_FINISH;
                        w_dec.status = sdspi_pkg::ST_UNSUPPORTED;
                    end else begin
                        w_dec.act = sdspi_pkg::ACT_CMD8;
                    end
                end
                sdspi_pkg::PH_CMD8: begin
                    if ((i_item.r1_byte & sdspi_pkg::R1_ILLEGAL) != 8'd0) begin
                        // no cmd8 support: older card, no high-capacity request
                        if (w_err != sdspi_pkg::ST_UNSUPPORTED) begin
                            w_dec.act    = sdspi_pkg::ACT_FINISH;
                            w_dec.status = w_err;
                        end else begin
                            w_dec.act = sdspi_pkg::ACT_CMD55_NEW;
                            w_dec.hcr = 1'b0;
                        end
                    end else if (w_err != sdspi_pkg::ST_OK) begin
                        w_dec.act    = sdspi_pkg::ACT_FINISH;
                        w_dec.status = w_err;
                    end else if (i_item.trailer[15:0] != sdspi_pkg::IF_COND_ECHO) begin
                        w_dec.act    = sdspi_pkg::ACT_FINISH;
                        w_dec.status = sdspi_pkg::ST_UNSUPPORTED;
                    end else begin
                        w_dec.act = sdspi_pkg::ACT_CMD55_NEW;
                        w_dec.hcr = 1'b1;
                    end
                end
                sdspi_pkg::PH_CMD55: begin
                    if (w_err != sdspi_pkg::ST_OK) begin
                        if (w_to_cmd1) begin
                            w_dec.act = sdspi_pkg::ACT_CMD1_NEW;
                        end else begin
                            w_dec.act    = sdspi_pkg::ACT_FINISH;
                            w_dec.status = w_err;
                        end
                    end else begin
                        w_dec.act = sdspi_pkg::ACT_ACMD41;
                    end
                end
                sdspi_pkg::PH_ACMD41, sdspi_pkg::PH_CMD1: begin
                    if (w_err != sdspi_pkg::ST_OK) begin
                        if (w_to_cmd1) begin
                            w_dec.act = sdspi_pkg::ACT_CMD1_NEW;
                        end else begin
                            w_dec.act    = sdspi_pkg::ACT_FINISH;
                            w_dec.status = w_err;
                        end
                    end else if ((i_item.r1_byte & sdspi_pkg::R1_IDLE) != 8'd0) begin
                        // still busy: retry while attempts remain
                        if (r_attempts <= 16'd1) begin
                            if (w_to_cmd1) begin
                                w_dec.act = sdspi_pkg::ACT_CMD1_NEW;
                            end else begin
                                w_dec.act    = sdspi_pkg::ACT_FINISH;
                                w_dec.status = sdspi_pkg::ST_NO_RESPONSE;
                            end
                        end else if (r_phase == sdspi_pkg::PH_CMD1) begin
                            w_dec.act = sdspi_pkg::ACT_CMD1_RETRY;
                        end else begin
                            w_dec.act = sdspi_pkg::ACT_CMD55_RETRY;
                        end
                    end else if (r_phase == sdspi_pkg::PH_ACMD41 && r_hcr) begin
                        w_dec.act = sdspi_pkg::ACT_CMD58;
                    end else begin
                        w_dec.act      = sdspi_pkg::ACT_CMD16;
                        w_dec.type_we  = 1'b1;
                        w_dec.new_type = (r_phase == sdspi_pkg::PH_CMD1)
                                       ? sdspi_pkg::CARD_MMC : sdspi_pkg::CARD_SD_V1;
                    end
                end
                sdspi_pkg::PH_CMD58: begin
                    if (w_err != sdspi_pkg::ST_OK) begin
                        w_dec.act    = sdspi_pkg::ACT_FINISH;
                        w_dec.status = w_err;
                    end else if (i_item.trailer[sdspi_pkg::CCS_BIT]) begin
                        w_dec.act      = sdspi_pkg::ACT_CMD9;
                        w_dec.type_we  = 1'b1;
                        w_dec.new_type = sdspi_pkg::CARD_SD_V2HC;
                    end else begin
                        w_dec.act      = sdspi_pkg::ACT_CMD16;
                        w_dec.type_we  = 1'b1;
                        w_dec.new_type = sdspi_pkg::CARD_SD_V2SC;
                    end
                end
                sdspi_pkg::PH_CMD16: begin
                    if (w_err != sdspi_pkg::ST_OK) begin
                        w_dec.act    = sdspi_pkg::ACT_FINISH;
                        w_dec.status = w_err;
                    end else begin
                        w_dec.act = sdspi_pkg::ACT_CMD9;
                    end
                end
                sdspi_pkg::PH_CMD9: begin
                    w_dec.act = sdspi_pkg::ACT_FINISH;
                    if (w_err != sdspi_pkg::ST_OK) begin
                        w_dec.status = w_err;
                    end else if (!w_csd.ok) begin
                        w_dec.status = sdspi_pkg::ST_UNSUPPORTED;
                    end else begin
                        w_dec.status = sdspi_pkg::ST_OK;
                    end
                end
                default: w_dec.act = sdspi_pkg::ACT_NONE;
            endcase
        end
    end

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_type     = r_type;
        n_attempts = r_attempts;
        n_hcr      = r_hcr;
        if (w_dec.clear) begin
            n_type     = sdspi_pkg::CARD_UNKNOWN;
            n_attempts = 16'd0;
            n_hcr      = 1'b0;
        end
        if (w_dec.type_we) begin
            n_type = w_dec.new_type;
        end
        unique case (w_dec.act)
            sdspi_pkg::ACT_NONE:   ;
            sdspi_pkg::ACT_FINISH: n_phase = sdspi_pkg::PH_IDLE;
            sdspi_pkg::ACT_CMD0:   n_phase = sdspi_pkg::PH_CMD0;
            sdspi_pkg::ACT_CMD8:   n_phase = sdspi_pkg::PH_CMD8;
            sdspi_pkg::ACT_CMD55_NEW: begin
                n_phase    = sdspi_pkg::PH_CMD55;
                n_attempts = i_cfg.retry_limit;
                n_hcr      = w_dec.hcr;
            end
            sdspi_pkg::ACT_CMD55_RETRY: begin
                n_phase    = sdspi_pkg::PH_CMD55;
                n_attempts = r_attempts - 16'd1;
            end
            sdspi_pkg::ACT_ACMD41: n_phase = sdspi_pkg::PH_ACMD41;
            sdspi_pkg::ACT_CMD1_NEW: begin
                n_phase    = sdspi_pkg::PH_CMD1;
                n_attempts = i_cfg.retry_limit;
            end
            sdspi_pkg::ACT_CMD1_RETRY: begin
                n_phase    = sdspi_pkg::PH_CMD1;
                n_attempts = r_attempts - 16'd1;
            end
            sdspi_pkg::ACT_CMD58: n_phase = sdspi_pkg::PH_CMD58;
            sdspi_pkg::ACT_CMD16: n_phase = sdspi_pkg::PH_CMD16;
            sdspi_pkg::ACT_CMD9:  n_phase = sdspi_pkg::PH_CMD9;
            default: ;
        endcase
    end

    // result
    always_comb begin
        o_res           = '0;
        o_res.resp_kind = sdspi_pkg::RESP_R1;
        o_res.status    = sdspi_pkg::ST_OK;
        o_res.card_type = sdspi_pkg::CARD_UNKNOWN;
        o_res_valid     = (w_dec.act != sdspi_pkg::ACT_NONE);
        unique case (w_dec.act)
            sdspi_pkg::ACT_NONE: ;
            sdspi_pkg::ACT_FINISH: begin
                o_res.done_res    = 1'b1;
                o_res.status      = w_dec.status;
                o_res.card_type   = w_dec.clear ? sdspi_pkg::CARD_UNKNOWN : r_type;
                o_res.block_count = (w_dec.status == sdspi_pkg::ST_OK) ? w_csd.count : 32'd0;
                o_res.fast_clock  = 1'b1;
            end
            sdspi_pkg::ACT_CMD0: o_res.cmd_index = sdspi_pkg::CMD_GO_IDLE;
            sdspi_pkg::ACT_CMD8: begin
                o_res.cmd_index = sdspi_pkg::CMD_IF_COND;
                o_res.cmd_arg   = sdspi_pkg::IF_COND_ARG;
                o_res.resp_kind = sdspi_pkg::RESP_R7;
            end
            sdspi_pkg::ACT_CMD55_NEW, sdspi_pkg::ACT_CMD55_RETRY:
                o_res.cmd_index = sdspi_pkg::CMD_APP;
            sdspi_pkg::ACT_ACMD41: begin
                o_res.cmd_index = sdspi_pkg::CMD_SD_OP_COND;
                o_res.cmd_arg   = r_hcr ? sdspi_pkg::HCS_ARG : 32'd0;
            end
            sdspi_pkg::ACT_CMD1_NEW, sdspi_pkg::ACT_CMD1_RETRY:
                o_res.cmd_index = sdspi_pkg::CMD_SEND_OP;
            sdspi_pkg::ACT_CMD58: begin
                o_res.cmd_index = sdspi_pkg::CMD_READ_OCR;
                o_res.resp_kind = sdspi_pkg::RESP_R3;
            end
            sdspi_pkg::ACT_CMD16: begin
                o_res.cmd_index = sdspi_pkg::CMD_BLOCKLEN;
                o_res.cmd_arg   = {19'd0, i_cfg.block_length};
            end
            sdspi_pkg::ACT_CMD9: begin
                o_res.cmd_index = sdspi_pkg::CMD_SEND_CSD;
                o_res.resp_kind = sdspi_pkg::RESP_R2;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= sdspi_pkg::PH_IDLE;
            r_type     <= sdspi_pkg::CARD_UNKNOWN;
            r_attempts <= 16'd0;
            r_hcr      <= 1'b0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_type     <= n_type;
            r_attempts <= n_attempts;
            r_hcr      <= n_hcr;
        end
    end

    assign o_phase = r_phase;

endmodule

/* src/sd_spi_card_init_controller.sv */
// top level of the sd spi-mode card initialisation sequencer
// depends on sdspi_pkg, sdspi_cfg_regs, sdspi_seq (and through it sdspi_csd)
//
// usage
//   input stream (s_axis_*): one item per start request or per card response.
//     tuser selects start (0) or response (1); tdata carries the card-detect
//     flag, the transport error flag, r1, the r3/r7 trailer and the csd.
//   output stream (m_axis_*): the next command to send (index, argument,
//     expected response kind) or, with tuser set, the final status, card
//     type and capacity in 512-byte blocks.
//   apb port: retry limit at byte address 0, cmd16 block length at 4.
//     to be written only while no item is in flight; the block does not enforce it.
//   an item is captured in the input register, and the decision logic
//     writes its result into the result register.
//   throughput is one item per cycle while the receiver accepts results;
//     the sequencer state register is the only loop.
//   a response while no sequence runs gives no result; a start item always
//     gives one, aborting whatever sequence was running.
//   reset returns to idle with the default retry limit (1000) and block
//     length (512). when the receiver stalls, the result register holds and
//     the input register takes at most one more item, until it too is full.
module sd_spi_card_init_controller (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // input item
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // [0] card_absent, [1] link_error, [9:2] r1_byte, [41:10] trailer,
    // [105:42] csd_high, [169:106] csd_low, [175:170] zero
    input  logic [175:0]  s_axis_tdata,
    // [0] op
    input  logic [0:0]    s_axis_tuser,
    // result item
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [5:0] cmd_index, [37:6] cmd_arg, [39:38] resp_kind, [42:40] status,
    // [45:43] card_type, [77:46] block_count, [78] fast_clock, [79] zero
    output logic [79:0]   m_axis_tdata,
    // [0] done_res
    output logic [0:0]    m_axis_tuser,
    // configuration
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    sdspi_pkg::t_cfg   w_cfg;
    sdspi_pkg::t_item  r_item;
    logic              r_in_valid;
    logic              w_fire;

    logic              w_res_valid;
    sdspi_pkg::t_res   w_res;
    sdspi_pkg::t_phase w_phase;
    logic              r_out_valid;
    sdspi_pkg::t_res   r_out;

    sdspi_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // decision stage advances when the result register is free or draining
    assign w_fire        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.op          <= s_axis_tuser[0];
            r_item.card_absent <= s_axis_tdata[0];
            r_item.link_error  <= s_axis_tdata[1];
            r_item.r1_byte     <= s_axis_tdata[9:2];
            r_item.trailer     <= s_axis_tdata[41:10];
            r_item.csd_high    <= s_axis_tdata[105:42];
            r_item.csd_low     <= s_axis_tdata[169:106];
        end
    end

    sdspi_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_item      (r_item),
        .i_cfg       (w_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_phase     (w_phase)
    );

    // result register; an item that causes no result simply leaves it empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= w_res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.done_res;
    assign m_axis_tdata  = {1'b0,
                            r_out.fast_clock,
                            r_out.block_count,
                            r_out.card_type,
                            r_out.status,
                            r_out.resp_kind,
                            r_out.cmd_arg,
                            r_out.cmd_index};

    // a final result always leaves the sequencer idle
    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_res_valid && w_res.done_res) |=> (w_phase == sdspi_pkg::PH_IDLE))
        else $error("sequencer not idle after final result");

    // a start item always produces a result
    a_start_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_item.op == sdspi_pkg::OP_START)) |=> r_out_valid)
        else $error("start item gave no result");

    // a capacity is only reported on a successful final result
    a_count_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[77:46] != 32'd0)) |->
            (m_axis_tuser[0] && (m_axis_tdata[42:40] == sdspi_pkg::ST_OK)))
        else $error("block count on a non-ok result");

    // a stalled result is never overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !w_fire)
        else $error("result register overwritten while stalled");

endmodule

/* test/sd_spi_card_init_controller_tb.sv */
// self-checking testbench for the sd spi-mode card initialisation sequencer
// drives start items and emulated card answers, checks every result against an
// in-bench prediction of the sequence; depends on sdspi_pkg and the top level
`timescale 1ns / 100ps

module sd_spi_card_init_controller_tb;

    import sdspi_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 80;
    localparam int PHASE_ITEMS    = 290;
    localparam t_res NO_RES       = '0;

    typedef struct {
        t_item it;
        bit    typed;
        t_res  want;
    } t_row;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    // [0] card_absent, [1] link_error, [9:2] r1_byte, [41:10] trailer,
    // [105:42] csd_high, [169:106] csd_low, [175:170] zero
    logic [175:0]  s_axis_tdata;
    // [0] op
    logic [0:0]    s_axis_tuser;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    // [5:0] cmd_index, [37:6] cmd_arg, [39:38] resp_kind, [42:40] status,
    // [45:43] card_type, [77:46] block_count, [78] fast_clock, [79] zero
    logic [79:0]   m_axis_tdata;
    // [0] done_res
    logic [0:0]    m_axis_tuser;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    // predicted sequencer state and register copies
    t_phase        seq_phase;
    t_card         found_type;
    logic [15:0]   tries_left;
    logic          hc_req;
    logic [15:0]   cfg_retries;
    logic [12:0]   cfg_blen;

    // emulated card behind the bus
    t_card         emu_kind;
    int            emu_busy;

    t_res          reply_q[$];
    int            items_taken;
    int            replies_seen;
    int            mismatches;
    int            ok_cards;
    int            exhausted;
    logic [4:0]    types_seen;
    int            idle_cycles;
    bit            calm;
    bit            hold_sink;

    sd_spi_card_init_controller DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // ---------------------------------------------------------------- prediction

    function automatic t_res mk_cmd(input logic [5:0] idx, input logic [31:0] arg,
                                    input t_resp kind);
        t_res r;
        r = '0;
        r.cmd_index = idx;
        r.cmd_arg   = arg;
        r.resp_kind = kind;
        return r;
    endfunction

    function automatic t_res mk_final(input t_status st, input t_card ty,
                                      input logic [31:0] count);
        t_res r;
        r = '0;
        r.done_res    = 1'b1;
        r.status      = st;
        r.card_type   = ty;
        r.block_count = count;
        r.fast_clock  = 1'b1;
        return r;
    endfunction

    // the capacity only survives an ok status
    function automatic t_res finish_seq(input t_status st, input logic [31:0] count);
        seq_phase = PH_IDLE;
        return mk_final(st, found_type, (st == ST_OK) ? count : 32'd0);
    endfunction

    // crc wins over erase, erase over parameter, parameter over illegal command
    function automatic t_status r1_fault(input logic [7:0] r1);
        if (r1[3]) return ST_CRC;
        if (r1[4] || r1[1]) return ST_ERASE;
        if (r1[6] || r1[5]) return ST_PARAM;
        if (r1[2]) return ST_UNSUPPORTED;
        return ST_OK;
    endfunction

    // a failing op-cond step drops an sd v1 attempt back to cmd1, else ends the run
    function automatic t_res give_up(input t_status st);
        if (seq_phase != PH_CMD1 && !hc_req) begin
            tries_left = cfg_retries;
            seq_phase  = PH_CMD1;
            return mk_cmd(CMD_SEND_OP, 32'd0, RESP_R1);
        end
        return finish_seq(st, 32'd0);
    endfunction

    function automatic bit predict_reply(input t_item it, output t_res r);
        t_status      fault;
        logic [127:0] csd;
        logic [4:0]   shift;
        logic [63:0]  amount;
        r = '0;
        if (it.op == OP_START) begin
            found_type = CARD_UNKNOWN;
            hc_req     = 1'b0;
            tries_left = '0;
            if (it.card_absent) begin
                r = finish_seq(ST_NO_CARD, 32'd0);
            end else begin
                seq_phase = PH_CMD0;
                r = mk_cmd(CMD_GO_IDLE, 32'd0, RESP_R1);
            end
            return 1'b1;
        end
        // an answer with no sequence running is dropped
        if (seq_phase == PH_IDLE) return 1'b0;
        if (it.link_error) begin
            if (seq_phase == PH_CMD55 || seq_phase == PH_ACMD41 || seq_phase == PH_CMD1) begin
                r = give_up(ST_LINK);
            end else begin
                r = finish_seq(ST_LINK, 32'd0);
            end
            return 1'b1;
        end
        fault = r1_fault(it.r1_byte);
        case (seq_phase)
            PH_CMD0: begin
                if (fault != ST_OK) r = finish_seq(fault, 32'd0);
                else if (!it.r1_byte[0]) r = finish_seq(ST_UNSUPPORTED, 32'd0);
                else begin
                    seq_phase = PH_CMD8;
                    r = mk_cmd(CMD_IF_COND, IF_COND_ARG, RESP_R7);
                end
            end
            PH_CMD8: begin
                // illegal command here means a v1 or mmc card, not a failure
                if (it.r1_byte[2] ? (fault != ST_UNSUPPORTED) : (fault != ST_OK)) begin
                    r = finish_seq(fault, 32'd0);
                end else if (!it.r1_byte[2] && it.trailer[15:0] != IF_COND_ECHO) begin
                    r = finish_seq(ST_UNSUPPORTED, 32'd0);
                end else begin
                    hc_req     = !it.r1_byte[2];
                    tries_left = cfg_retries;
                    seq_phase  = PH_CMD55;
                    r = mk_cmd(CMD_APP, 32'd0, RESP_R1);
                end
            end
            PH_CMD55: begin
                if (fault != ST_OK) r = give_up(fault);
                else begin
                    seq_phase = PH_ACMD41;
                    r = mk_cmd(CMD_SD_OP_COND, hc_req ? HCS_ARG : 32'd0, RESP_R1);
                end
            end
            PH_ACMD41, PH_CMD1: begin
                if (fault != ST_OK) begin
                    r = give_up(fault);
                end else if (it.r1_byte[0]) begin
                    // still busy: retry unless this was the last allowed attempt
                    if (tries_left <= 16'd1) r = give_up(ST_NO_RESPONSE);
                    else begin
                        tries_left = tries_left - 16'd1;
                        if (seq_phase == PH_CMD1) begin
                            r = mk_cmd(CMD_SEND_OP, 32'd0, RESP_R1);
                        end else begin
                            seq_phase = PH_CMD55;
                            r = mk_cmd(CMD_APP, 32'd0, RESP_R1);
                        end
                    end
                end else if (seq_phase == PH_ACMD41 && hc_req) begin
                    seq_phase = PH_CMD58;
                    r = mk_cmd(CMD_READ_OCR, 32'd0, RESP_R3);
                end else begin
                    found_type = (seq_phase == PH_CMD1) ? CARD_MMC : CARD_SD_V1;
                    seq_phase  = PH_CMD16;
                    r = mk_cmd(CMD_BLOCKLEN, {19'd0, cfg_blen}, RESP_R1);
                end
            end
            PH_CMD58: begin
                if (fault != ST_OK) r = finish_seq(fault, 32'd0);
                else if (it.trailer[CCS_BIT]) begin
                    found_type = CARD_SD_V2HC;
                    seq_phase  = PH_CMD9;
                    r = mk_cmd(CMD_SEND_CSD, 32'd0, RESP_R2);
                end else begin
                    found_type = CARD_SD_V2SC;
                    seq_phase  = PH_CMD16;
                    r = mk_cmd(CMD_BLOCKLEN, {19'd0, cfg_blen}, RESP_R1);
                end
            end
            PH_CMD16: begin
                if (fault != ST_OK) r = finish_seq(fault, 32'd0);
                else begin
                    seq_phase = PH_CMD9;
                    r = mk_cmd(CMD_SEND_CSD, 32'd0, RESP_R2);
                end
            end
            default: begin
                csd = {it.csd_high, it.csd_low};
                if (fault != ST_OK) begin
                    r = finish_seq(fault, 32'd0);
                end else if (!((csd[127:126] == 2'd0 && (found_type == CARD_SD_V1 ||
                                                          found_type == CARD_SD_V2SC)) ||
                               (csd[127:126] == 2'd1 && found_type == CARD_SD_V2HC) ||
                               (csd[127:126] <= 2'd1 && found_type == CARD_MMC))) begin
                    r = finish_seq(ST_UNSUPPORTED, 32'd0);
                end else if (found_type == CARD_SD_V2HC) begin
                    // v2: 22-bit c_size in 512 kbyte units, saturating at 32 bits
                    amount = (64'(csd[69:48]) + 64'd1) * 64'd1024;
                    r = finish_seq(ST_OK, (amount > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                   : amount[31:0]);
                end else begin
                    // v1 / mmc: (c_size + 1) << (c_size_mult + 2 + read_bl_len) bytes
                    shift  = {2'd0, csd[49:47]} + 5'd2 + {1'b0, csd[83:80]};
                    amount = (64'(csd[73:62]) + 64'd1) << shift;
                    r = finish_seq(ST_OK, amount[40:9]);
                end
            end
        endcase
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic t_item go(input logic absent);
        t_item it;
        it = '0;
        it.op          = OP_START;
        it.card_absent = absent;
        return it;
    endfunction

    function automatic t_item answer(input logic [7:0] r1, input logic [31:0] tail = 32'd0,
                                     input logic link = 1'b0, input logic [63:0] hi = 64'd0,
                                     input logic [63:0] lo = 64'd0);
        t_item it;
        it = '0;
        it.op         = OP_RESP;
        it.r1_byte    = r1;
        it.trailer    = tail;
        it.link_error = link;
        it.csd_high   = hi;
        it.csd_low    = lo;
        return it;
    endfunction

    function automatic void new_card();
        emu_kind = t_card'(3'($urandom_range(1, 4)));
        emu_busy = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(3, 8);
    endfunction

    // plausible card answer to whatever command is outstanding, with some noise
    function automatic t_item card_item();
        t_item it;
        int    roll;
        it.op          = OP_RESP;
        it.card_absent = 1'($urandom_range(0, 1));
        it.link_error  = ($urandom_range(0, 99) < 2);
        it.r1_byte     = 8'h00;
        it.trailer     = $urandom;
        it.csd_high    = {$urandom, $urandom};
        it.csd_low     = {$urandom, $urandom};
        roll = $urandom_range(0, 99);
        if (seq_phase == PH_IDLE) begin
            if (roll < 88) begin
                it.op          = OP_START;
                it.card_absent = ($urandom_range(0, 19) == 0);
                new_card();
            end else begin
                it.r1_byte = 8'($urandom);
            end
            return it;
        end
        // occasional restart in the middle of a sequence
        if (roll == 0) begin
            it.op          = OP_START;
            it.card_absent = 1'b0;
            new_card();
            return it;
        end
        case (seq_phase)
            PH_CMD0: it.r1_byte = R1_IDLE;
            PH_CMD8: begin
                if (emu_kind == CARD_SD_V2HC || emu_kind == CARD_SD_V2SC) begin
                    it.r1_byte = R1_IDLE;
                    if ($urandom_range(0, 19) != 0) it.trailer[15:0] = IF_COND_ECHO;
                end else begin
                    it.r1_byte = R1_IDLE | R1_ILLEGAL;
                end
            end
            PH_CMD55: it.r1_byte = 8'($urandom_range(0, 1));
            PH_ACMD41, PH_CMD1: begin
                if (seq_phase == PH_ACMD41 && emu_kind == CARD_MMC) begin
                    it.r1_byte = R1_IDLE | R1_ILLEGAL;
                end else if (emu_busy > 0) begin
                    it.r1_byte = R1_IDLE;
                    emu_busy--;
                end
            end
            PH_CMD58: it.trailer[CCS_BIT] = (emu_kind == CARD_SD_V2HC);
            PH_CMD9: begin
                if ($urandom_range(0, 14) != 0) begin
                    if (emu_kind == CARD_SD_V2HC) it.csd_high[63:62] = 2'd1;
                    else if (emu_kind == CARD_MMC) it.csd_high[63:62] = 2'($urandom_range(0, 1));
                    else it.csd_high[63:62] = 2'd0;
                end
            end
            default: it.r1_byte = 8'h00;
        endcase
        if (roll >= 94) it.r1_byte = 8'($urandom);
        return it;
    endfunction

    // mostly short gaps, a few long ones, none during calm stretches
    function automatic int pick_gap();
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic offer(input t_item it, input bit typed, input t_res typed_want,
                         output bit produced);
        t_res guess;
        int   gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, it.csd_low, it.csd_high, it.trailer, it.r1_byte,
                          it.link_error, it.card_absent};
        s_axis_tuser  <= it.op;
        do @(posedge i_clk); while (!s_axis_tready);
        items_taken++;
        produced = predict_reply(it, guess);
        if (typed) reply_q.push_back(typed_want);
        else if (produced) reply_q.push_back(guess);
    endtask

    // stop offering and let every outstanding result (and any dropped item) pass
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [15:0] retries, input logic [12:0] blen);
        reg_write({REG_RETRY_LIMIT, 2'b00}, {16'd0, retries});
        cfg_retries = retries;
        reg_write({REG_BLOCK_LENGTH, 2'b00}, {19'd0, blen});
        cfg_blen = blen;
    endtask

    // ---------------------------------------------------------------- result checking

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            replies_seen++;
            if (reply_q.size() == 0) begin
                mismatches++;
                $display("%0t: result with nothing expected, got user %0h data %0h",
                         $time, m_axis_tuser, m_axis_tdata);
            end else begin
                want = reply_q.pop_front();
                check_field("cmd_index", 32'(want.cmd_index), 32'(m_axis_tdata[5:0]));
                check_field("cmd_arg", want.cmd_arg, m_axis_tdata[37:6]);
                check_field("resp_kind", 32'(want.resp_kind), 32'(m_axis_tdata[39:38]));
                check_field("done_res", 32'(want.done_res), 32'(m_axis_tuser[0]));
                check_field("status", 32'(want.status), 32'(m_axis_tdata[42:40]));
                check_field("card_type", 32'(want.card_type), 32'(m_axis_tdata[45:43]));
                check_field("block_count", want.block_count, m_axis_tdata[77:46]);
                check_field("fast_clock", 32'(want.fast_clock), 32'(m_axis_tdata[78]));
                if (want.done_res && want.status == ST_OK) begin
                    ok_cards++;
                    types_seen[want.card_type] = 1'b1;
                end
                if (want.done_res && want.status == ST_NO_RESPONSE) exhausted++;
            end
        end
    end

    // receiver pacing, with one long hold-off on request
    initial begin : sink_pacing
        int off;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_sink) begin
                hold_sink = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                off = pick_gap();
                if (off > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (off) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // give up when nothing moves on any port for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pwrite)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, reply_q.size());
            $display("sd_spi_card_init_controller_tb: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin : stimulus
        t_row        plan[$];
        t_item       it;
        bit          produced;
        int          taken;
        logic [15:0] retry_set[6];
        logic [12:0] blen_set[6];

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        idle_cycles   = 0;
        items_taken   = 0;
        replies_seen  = 0;
        mismatches    = 0;
        ok_cards      = 0;
        exhausted     = 0;
        types_seen    = '0;
        calm          = 1'b0;
        hold_sink     = 1'b0;
        cfg_retries   = RETRY_LIMIT_RST;
        cfg_blen      = BLOCK_LENGTH_RST;
        seq_phase     = PH_IDLE;
        found_type    = CARD_UNKNOWN;
        tries_left    = '0;
        hc_req        = 1'b0;
        emu_kind      = CARD_SD_V2HC;
        emu_busy      = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk through the main paths and the corner cases
        plan.push_back('{answer(R1_IDLE), 1'b0, NO_RES});   // stray answer after reset
        plan.push_back('{go(1'b1), 1'b1, mk_final(ST_NO_CARD, CARD_UNKNOWN, 32'd0)});
        plan.push_back('{go(1'b0), 1'b1, mk_cmd(CMD_GO_IDLE, 32'd0, RESP_R1)});
        plan.push_back('{answer(R1_CRC | R1_IDLE), 1'b1,
                         mk_final(ST_CRC, CARD_UNKNOWN, 32'd0)});
        // high-capacity card with one busy round and a saturating capacity
        plan.push_back('{go(1'b0), 1'b1, mk_cmd(CMD_GO_IDLE, 32'd0, RESP_R1)});
        plan.push_back('{answer(R1_IDLE), 1'b1, mk_cmd(CMD_IF_COND, IF_COND_ARG, RESP_R7)});
        plan.push_back('{answer(R1_IDLE, 32'hFFFF_01AA), 1'b1,
                         mk_cmd(CMD_APP, 32'd0, RESP_R1)});
        plan.push_back('{answer(8'h81), 1'b1, mk_cmd(CMD_SD_OP_COND, HCS_ARG, RESP_R1)});
        plan.push_back('{answer(R1_IDLE), 1'b1, mk_cmd(CMD_APP, 32'd0, RESP_R1)});
        plan.push_back('{answer(8'h00), 1'b1, mk_cmd(CMD_SD_OP_COND, HCS_ARG, RESP_R1)});
        plan.push_back('{answer(8'h00), 1'b1, mk_cmd(CMD_READ_OCR, 32'd0, RESP_R3)});
        plan.push_back('{answer(8'h00, HCS_ARG), 1'b1, mk_cmd(CMD_SEND_CSD, 32'd0, RESP_R2)});
        plan.push_back('{answer(8'h00, 32'd0, 1'b0, 64'h4000_0000_0000_003F,
                                64'hFFFF_0000_0000_0000), 1'b1,
                         mk_final(ST_OK, CARD_SD_V2HC, 32'hFFFF_FFFF)});
        // v1 path refused by the card, falling back to cmd1, then a link failure
        plan.push_back('{go(1'b0), 1'b1, mk_cmd(CMD_GO_IDLE, 32'd0, RESP_R1)});
        plan.push_back('{answer(R1_IDLE), 1'b1, mk_cmd(CMD_IF_COND, IF_COND_ARG, RESP_R7)});
        plan.push_back('{answer(R1_IDLE | R1_ILLEGAL), 1'b1, mk_cmd(CMD_APP, 32'd0, RESP_R1)});
        plan.push_back('{answer(R1_IDLE), 1'b1, mk_cmd(CMD_SD_OP_COND, 32'd0, RESP_R1)});
        plan.push_back('{answer(R1_ILLEGAL), 1'b1, mk_cmd(CMD_SEND_OP, 32'd0, RESP_R1)});
        plan.push_back('{answer(8'h00), 1'b1,
                         mk_cmd(CMD_BLOCKLEN, {19'd0, BLOCK_LENGTH_RST}, RESP_R1)});
        plan.push_back('{answer(8'h00), 1'b0, NO_RES});
        plan.push_back('{answer(8'h00, 32'd0, 1'b1), 1'b1,
                         mk_final(ST_LINK, CARD_MMC, 32'd0)});
        // bad echo on cmd8, parameter error on cmd0
        plan.push_back('{go(1'b0), 1'b0, NO_RES});
        plan.push_back('{answer(R1_IDLE), 1'b0, NO_RES});
        plan.push_back('{answer(R1_IDLE, 32'h0000_01AB), 1'b1,
                         mk_final(ST_UNSUPPORTED, CARD_UNKNOWN, 32'd0)});
        plan.push_back('{go(1'b0), 1'b0, NO_RES});
        plan.push_back('{answer(8'h40), 1'b1, mk_final(ST_PARAM, CARD_UNKNOWN, 32'd0)});

        foreach (plan[i]) offer(plan[i].it, plan[i].typed, plan[i].want, produced);

        // random sequences under several register settings, extremes first
        retry_set = '{16'd1, 16'd65535, 16'd0, 16'd2, 16'd3, 16'($urandom_range(4, 40))};
        blen_set  = '{13'd1, 13'd4096, 13'($urandom_range(1, 4096)),
                      13'($urandom_range(1, 4096)), 13'd512, 13'($urandom_range(1, 4096))};
        for (int ph = 0; ph < 6; ph++) begin
            wait_quiet();
            configure(retry_set[ph], blen_set[ph]);
            taken = 0;
            calm  = 1'b1;
            while (taken < PHASE_ITEMS) begin
                if (taken == 60) calm = 1'b0;
                // receiver holds off while items keep coming, so the block backs up
                if (ph == 0 && taken == 120) hold_sink = 1'b1;
                // sender pauses until the pipeline is empty
                if (ph == 1 && taken == 150) wait_quiet();
                it = card_item();
                offer(it, 1'b0, NO_RES, produced);
                if (produced) taken++;
            end
        end

        wait_quiet();
        repeat (8) @(posedge i_clk);
        $display("run covered %0d items and %0d results over 6 register settings",
                 items_taken, replies_seen);
        $display("%0d cards identified (type mask %b), %0d retry exhaustions",
                 ok_cards, types_seen, exhausted);
        if (mismatches == 0 && reply_q.size() == 0) begin
            $display("sd_spi_card_init_controller_tb: PASS");
        end else begin
            $display("sd_spi_card_init_controller_tb: FAIL");
        end
        $finish;
    end

endmodule
